>>> rtl/core/power_bispectrum_chi2_core_assert.svh
// Assertion macros for the power / bispectrum chi-square core.
// Needs clk and arst_n in the scope of use; empty when SYNTHESIS is defined.
`ifndef POWER_BISPECTRUM_CHI2_CORE_ASSERT_SVH
`define POWER_BISPECTRUM_CHI2_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PBC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PBC_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define PBC_ASSERT(lbl, prop, msg)
`define PBC_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

>>> rtl/core/pbc_pkg.sv
// Shared types and constants of the power / bispectrum chi-square core.
// No dependencies; used by power_bispectrum_chi2_core.
`timescale 1ns / 1ps
`default_nettype none

package pbc_pkg;

	localparam int NUM_UV_DEF = 256;

	localparam int Q_W    = 24;
	localparam int FRAC_W = 20;
	localparam int SUM_W  = 48;
	localparam int MUL_W  = 25;
	localparam int PROD_W = 50;
	localparam int ACC_W  = 51;
	localparam int SQ_W   = PROD_W - FRAC_W;
	localparam int PC_W   = 5;

	localparam logic [PC_W-1:0] PC_POWER_LAST = 5'd8;
	localparam logic [PC_W-1:0] PC_BISP_LAST  = 5'd26;

	localparam logic signed [Q_W-1:0] Q_MAX = 24'sh7FFFFF;
	localparam logic signed [Q_W-1:0] Q_MIN = 24'sh800000;

	localparam logic signed [ACC_W:0] ACC_HALF = 52'sd524288;
	localparam logic signed [ACC_W:0] RND_MAX  = 52'sd8388607;
	localparam logic signed [ACC_W:0] RND_MIN  = -52'sd8388608;
	localparam logic [PROD_W:0]       SQ_HALF  = 51'd524288;

	typedef enum logic [1:0] {
		CMD_STORE = 2'd0,
		CMD_POWER = 2'd1,
		CMD_BISP  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_A,
		ST_RD_B,
		ST_RD_C,
		ST_CALC
	} state_t;

	typedef enum logic [2:0] {
		M_NONE,
		M_XR_YR,
		M_XI_YI,
		M_XR_YI,
		M_XI_YR,
		M_RES_RE,
		M_RES_IM,
		M_SQ
	} mul_sel_t;

	typedef enum logic [1:0] {
		A_NONE,
		A_LOAD,
		A_ADD,
		A_SUB
	} acc_op_t;

	typedef enum logic [1:0] {
		F_NONE,
		F_TR,
		F_TI,
		F_RES
	} fin_t;

	typedef enum logic [1:0] {
		Y_NONE,
		Y_C,
		Y_PH
	} y_sel_t;

	typedef struct packed {
		mul_sel_t mul;
		acc_op_t  acc;
		fin_t     fin;
		y_sel_t   ysel;
		logic     chi;
		logic     done;
	} uop_t;

	typedef struct packed {
		logic [1:0]              command;
		logic [7:0]              index_a;
		logic [7:0]              index_b;
		logic [7:0]              index_c;
		logic [2:0]              sign_bits;
		logic signed [Q_W-1:0]   value_re;
		logic signed [Q_W-1:0]   value_im;
		logic signed [Q_W-1:0]   measured;
		logic signed [Q_W-1:0]   weight_re;
		logic signed [Q_W-1:0]   weight_im;
		logic                    last_item;
	} req_t;

	typedef struct packed {
		logic signed [Q_W-1:0]   model_re;
		logic signed [Q_W-1:0]   model_im;
		logic [SUM_W-1:0]        chi2_sum;
		logic                    sum_done;
		logic                    saturated;
	} res_t;

endpackage

`default_nettype wire

>>> rtl/core/power_bispectrum_chi2_core.sv
// Power / bispectrum chi-square core: visibility store, micro-sequenced
// shared 25x25 multiplier, rounding/saturation and the chi-square sum.
// Depends on pbc_pkg and power_bispectrum_chi2_core_assert.svh.
//
// Usage:
//  - Request channel (req_valid/req_ready/req_data): a store request writes
//    one visibility; ready stays high. Command three is taken and dropped.
//  - Power and bispectrum requests hold ready low while they run: power does
//    one store read, then 9 sequencer steps, 4 of them products; bispectrum
//    three store reads, then 27 steps of the multiply / accumulate sequencer,
//    16 of them products through the single shared multiplier. Ready returns
//    as the result is loaded, so a new point is taken only once the last one
//    is through.
//  - Result channel (res_valid/res_ready/res_data): one result per power or
//    bispectrum request, held in an output register. A new request is taken
//    while a result waits; if the next result is ready before the old one is
//    taken, the sequencer holds on its last step until the register frees.
//  - chi2_sum is the running sum including the request; after a request
//    marked last_item the sum restarts from zero.
//  - Reset clears the sum, the sequencer and the result valid; the
//    visibility store is not cleared and must be written before it is read.
`timescale 1ns / 1ps
`default_nettype none
`include "power_bispectrum_chi2_core_assert.svh"

module power_bispectrum_chi2_core #(
	parameter int NUM_UV = pbc_pkg::NUM_UV_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  pbc_pkg::req_t req_data,
	output logic          res_valid,
	input  logic          res_ready,
	output pbc_pkg::res_t res_data
);

	localparam int AW = (NUM_UV > 1) ? $clog2(NUM_UV) : 1;
	localparam int QW = pbc_pkg::Q_W;

	pbc_pkg::state_t state_q, state_d;
	logic [pbc_pkg::PC_W-1:0] pc_q;
	pbc_pkg::req_t item_q;
	pbc_pkg::res_t out_q;
	pbc_pkg::uop_t u;
	logic res_valid_q;
	logic sat_q;
	logic [pbc_pkg::SUM_W-1:0] chi_q;

	logic signed [QW-1:0] xr_q, xi_q, yr_q, yi_q, cr_q, ci_q, resid_q;
	logic signed [pbc_pkg::PROD_W-1:0] prod_q;
	logic signed [pbc_pkg::ACC_W-1:0] acc_q;

	logic [2*QW-1:0] mem [NUM_UV];
	logic [2*QW-1:0] rd_q;
	logic rd_ok_q;

	logic accept;
	logic is_bisp;
	logic step_go;
	logic [7:0] ridx;
	logic rd_ok_d;
	logic we;
	logic signed [QW-1:0] rd_re, rd_im, conj_im;
	logic conj_en, conj_sat;

	logic signed [pbc_pkg::MUL_W-1:0] ma, mb, diff_re;
	logic signed [pbc_pkg::PROD_W-1:0] mul_p;
	logic signed [pbc_pkg::ACC_W-1:0] prod_ext;
	logic signed [pbc_pkg::ACC_W:0] rnd_sum, rnd_val;
	logic signed [QW-1:0] fin_val;
	logic fin_sat;
	logic [pbc_pkg::PROD_W:0] sq_sum;
	logic [pbc_pkg::SQ_W-1:0] sq;
	logic [pbc_pkg::SUM_W:0] chi_add;
	logic [pbc_pkg::SUM_W-1:0] chi_new;
	logic chi_ovf;

	logic point_acc, store_acc, pc_over;

	assign is_bisp = (item_q.command == pbc_pkg::CMD_BISP);
	assign accept = req_valid && req_ready;
	assign res_valid = res_valid_q;
	assign res_data = out_q;

	// ---------------- sequencer: next state, read address, micro-op ----------------
	always_comb begin
		state_d = state_q;
		req_ready = (state_q == pbc_pkg::ST_IDLE);
		u = '0;
		conj_en = 1'b0;

		case (state_q)
			pbc_pkg::ST_IDLE: ridx = req_data.index_a;
			pbc_pkg::ST_RD_A: ridx = item_q.index_b;
			default:          ridx = item_q.index_c;
		endcase

		if (state_q == pbc_pkg::ST_CALC) begin
			if (is_bisp) begin
				case (pc_q)
					5'd0, 5'd6, 5'd12: u.mul = pbc_pkg::M_XR_YR;
					5'd1, 5'd7, 5'd13: begin
						u.mul = pbc_pkg::M_XI_YI;
						u.acc = pbc_pkg::A_LOAD;
					end
					5'd2, 5'd8, 5'd14: begin
						u.mul = pbc_pkg::M_XR_YI;
						u.acc = pbc_pkg::A_SUB;
					end
					5'd3, 5'd9, 5'd15: begin
						u.mul = pbc_pkg::M_XI_YR;
						u.acc = pbc_pkg::A_LOAD;
						u.fin = pbc_pkg::F_TR;
					end
					5'd4, 5'd10, 5'd16: u.acc = pbc_pkg::A_ADD;
					5'd5: begin
						u.fin = pbc_pkg::F_TI;
						u.ysel = pbc_pkg::Y_C;
					end
					5'd11: begin
						u.fin = pbc_pkg::F_TI;
						u.ysel = pbc_pkg::Y_PH;
					end
					5'd17: u.fin = pbc_pkg::F_TI;
					5'd18: u.mul = pbc_pkg::M_RES_RE;
					5'd19, 5'd23: u.acc = pbc_pkg::A_LOAD;
					5'd20, 5'd24: u.fin = pbc_pkg::F_RES;
					5'd21, 5'd25: u.mul = pbc_pkg::M_SQ;
					5'd22: begin
						u.chi = 1'b1;
						u.mul = pbc_pkg::M_RES_IM;
					end
					5'd26: begin
						u.chi = 1'b1;
						u.done = 1'b1;
					end
					default: u = '0;
				endcase
			end else begin
				case (pc_q)
					5'd0: u.mul = pbc_pkg::M_XR_YR;
					5'd1: begin
						u.mul = pbc_pkg::M_XI_YI;
						u.acc = pbc_pkg::A_LOAD;
					end
					5'd2: u.acc = pbc_pkg::A_ADD;
					5'd3: u.fin = pbc_pkg::F_TR;
					5'd4: u.mul = pbc_pkg::M_RES_RE;
					5'd5: u.acc = pbc_pkg::A_LOAD;
					5'd6: u.fin = pbc_pkg::F_RES;
					5'd7: u.mul = pbc_pkg::M_SQ;
					5'd8: begin
						u.chi = 1'b1;
						u.done = 1'b1;
					end
					default: u = '0;
				endcase
			end
		end

		// hold the last step while the previous result still waits
		step_go = (state_q == pbc_pkg::ST_CALC) && !(u.done && res_valid_q && !res_ready);

		case (state_q)
			pbc_pkg::ST_IDLE: begin
				if (accept && (req_data.command == pbc_pkg::CMD_POWER ||
						req_data.command == pbc_pkg::CMD_BISP)) begin
					state_d = pbc_pkg::ST_RD_A;
				end
			end
			pbc_pkg::ST_RD_A: begin
				conj_en = is_bisp && item_q.sign_bits[0];
				state_d = is_bisp ? pbc_pkg::ST_RD_B : pbc_pkg::ST_CALC;
			end
			pbc_pkg::ST_RD_B: begin
				conj_en = item_q.sign_bits[1];
				state_d = pbc_pkg::ST_RD_C;
			end
			pbc_pkg::ST_RD_C: begin
				conj_en = item_q.sign_bits[2];
				state_d = pbc_pkg::ST_CALC;
			end
			pbc_pkg::ST_CALC: begin
				if (step_go && u.done) begin
					state_d = pbc_pkg::ST_IDLE;
				end
			end
			default: state_d = pbc_pkg::ST_IDLE;
		endcase
	end

	// ---------------- visibility store ----------------
	assign rd_ok_d = (32'(ridx) < NUM_UV);
	assign we = accept && (req_data.command == pbc_pkg::CMD_STORE) &&
		(32'(req_data.index_a) < NUM_UV);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[AW'(req_data.index_a)] <= {req_data.value_re, req_data.value_im};
		end
		rd_q <= mem[AW'(ridx)];
		rd_ok_q <= rd_ok_d;
	end

	// out-of-range slots read as zero
	assign rd_re = rd_ok_q ? $signed(rd_q[2*QW-1:QW]) : '0;
	assign rd_im = rd_ok_q ? $signed(rd_q[QW-1:0]) : '0;

	always_comb begin
		conj_sat = 1'b0;
		conj_im = rd_im;
		if (conj_en) begin
			if (rd_im == pbc_pkg::Q_MIN) begin
				conj_sat = 1'b1;
				conj_im = pbc_pkg::Q_MAX;
			end else begin
				conj_im = -rd_im;
			end
		end
	end

	// ---------------- shared multiplier ----------------
	assign diff_re = {xr_q[QW-1], xr_q} - {item_q.measured[QW-1], item_q.measured};

	always_comb begin
		case (u.mul)
			pbc_pkg::M_XR_YR: begin
				ma = {xr_q[QW-1], xr_q};
				mb = {yr_q[QW-1], yr_q};
			end
			pbc_pkg::M_XI_YI: begin
				ma = {xi_q[QW-1], xi_q};
				mb = {yi_q[QW-1], yi_q};
			end
			pbc_pkg::M_XR_YI: begin
				ma = {xr_q[QW-1], xr_q};
				mb = {yi_q[QW-1], yi_q};
			end
			pbc_pkg::M_XI_YR: begin
				ma = {xi_q[QW-1], xi_q};
				mb = {yr_q[QW-1], yr_q};
			end
			pbc_pkg::M_RES_RE: begin
				ma = diff_re;
				mb = {item_q.weight_re[QW-1], item_q.weight_re};
			end
			pbc_pkg::M_RES_IM: begin
				ma = {xi_q[QW-1], xi_q};
				mb = {item_q.weight_im[QW-1], item_q.weight_im};
			end
			pbc_pkg::M_SQ: begin
				ma = {resid_q[QW-1], resid_q};
				mb = {resid_q[QW-1], resid_q};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign mul_p = ma * mb;
	assign prod_ext = {prod_q[pbc_pkg::PROD_W-1], prod_q};

	// round half up to Q3.20, then clamp to 24 bits
	assign rnd_sum = {acc_q[pbc_pkg::ACC_W-1], acc_q} + pbc_pkg::ACC_HALF;
	assign rnd_val = rnd_sum >>> pbc_pkg::FRAC_W;

	always_comb begin
		fin_sat = 1'b0;
		fin_val = rnd_val[QW-1:0];
		if (rnd_val > pbc_pkg::RND_MAX) begin
			fin_sat = 1'b1;
			fin_val = pbc_pkg::Q_MAX;
		end else if (rnd_val < pbc_pkg::RND_MIN) begin
			fin_sat = 1'b1;
			fin_val = pbc_pkg::Q_MIN;
		end
	end

	// squared residual is never negative
	assign sq_sum = {1'b0, prod_q} + pbc_pkg::SQ_HALF;
	assign sq = sq_sum[pbc_pkg::PROD_W-1:pbc_pkg::FRAC_W];
	assign chi_add = {1'b0, chi_q} + {{(pbc_pkg::SUM_W + 1 - pbc_pkg::SQ_W){1'b0}}, sq};
	assign chi_ovf = chi_add[pbc_pkg::SUM_W];
	assign chi_new = chi_ovf ? '1 : chi_add[pbc_pkg::SUM_W-1:0];

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pbc_pkg::ST_IDLE;
			pc_q <= '0;
			res_valid_q <= 1'b0;
			chi_q <= '0;
			sat_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (accept) begin
				sat_q <= 1'b0;
			end
			if (conj_sat) begin
				sat_q <= 1'b1;
			end
			if (step_go) begin
				if (u.fin != pbc_pkg::F_NONE && fin_sat) begin
					sat_q <= 1'b1;
				end
				if (u.chi) begin
					chi_q <= chi_new;
					if (chi_ovf) begin
						sat_q <= 1'b1;
					end
				end
				if (u.done) begin
					res_valid_q <= 1'b1;
					pc_q <= '0;
					if (item_q.last_item) begin
						chi_q <= '0;
					end
				end else begin
					pc_q <= pc_q + 1'b1;
				end
			end
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req_data;
		end
		case (state_q)
			pbc_pkg::ST_RD_A: begin
				xr_q <= rd_re;
				xi_q <= conj_im;
				yr_q <= rd_re;
				yi_q <= conj_im;
			end
			pbc_pkg::ST_RD_B: begin
				yr_q <= rd_re;
				yi_q <= conj_im;
			end
			pbc_pkg::ST_RD_C: begin
				cr_q <= rd_re;
				ci_q <= conj_im;
			end
			default: ;
		endcase
		if (step_go) begin
			prod_q <= mul_p;
			case (u.acc)
				pbc_pkg::A_LOAD: acc_q <= prod_ext;
				pbc_pkg::A_ADD:  acc_q <= acc_q + prod_ext;
				pbc_pkg::A_SUB:  acc_q <= acc_q - prod_ext;
				default: ;
			endcase
			case (u.fin)
				pbc_pkg::F_TR:  xr_q <= fin_val;
				pbc_pkg::F_TI:  xi_q <= fin_val;
				pbc_pkg::F_RES: resid_q <= fin_val;
				default: ;
			endcase
			case (u.ysel)
				pbc_pkg::Y_C: begin
					yr_q <= cr_q;
					yi_q <= ci_q;
				end
				pbc_pkg::Y_PH: begin
					yr_q <= item_q.value_re;
					yi_q <= item_q.value_im;
				end
				default: ;
			endcase
			if (u.done) begin
				out_q.model_re <= xr_q;
				out_q.model_im <= is_bisp ? xi_q : '0;
				out_q.chi2_sum <= chi_new;
				out_q.sum_done <= item_q.last_item;
				out_q.saturated <= sat_q | chi_ovf;
			end
		end
	end

	// ---------------- assertions ----------------
	assign point_acc = accept && (req_data.command == pbc_pkg::CMD_POWER ||
		req_data.command == pbc_pkg::CMD_BISP);
	assign store_acc = accept && (req_data.command == pbc_pkg::CMD_STORE);
	assign pc_over = is_bisp ? (pc_q > pbc_pkg::PC_BISP_LAST) : (pc_q > pbc_pkg::PC_POWER_LAST);

	`PBC_ASSERT(a_point_goes_busy, point_acc |=> !req_ready, "point request did not drop ready")
	`PBC_ASSERT(a_store_stays_ready, store_acc |=> req_ready, "store request dropped ready")
	`PBC_ASSERT(a_sum_cleared, $rose(res_valid) && res_data.sum_done |-> chi_q == '0, "sum not reset")
	`PBC_ASSERT_NEVER(a_pc_range, (state_q == pbc_pkg::ST_CALC) && pc_over, "step out of range")

endmodule

`default_nettype wire
